### design/sm83_alu_pkg.sv
// Package with the operation codes, flag positions and transaction types of the SM83 ALU.
`default_nettype none

package sm83_alu_pkg;

  localparam int unsigned OP_W    = 5;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned BIDX_W  = 3;
  localparam int unsigned FLAGS_W = 4;

  // Positions of the flags in the flag nibble.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 5'd0,
    OP_ADC    = 5'd1,
    OP_SUB    = 5'd2,
    OP_SBC    = 5'd3,
    OP_AND    = 5'd4,
    OP_XOR    = 5'd5,
    OP_OR     = 5'd6,
    OP_CP     = 5'd7,
    OP_RLCA   = 5'd8,
    OP_RRCA   = 5'd9,
    OP_RLA    = 5'd10,
    OP_RRA    = 5'd11,
    OP_DAA    = 5'd12,
    OP_CPL    = 5'd13,
    OP_SCF    = 5'd14,
    OP_CCF    = 5'd15,
    OP_RLC    = 5'd16,
    OP_RRC    = 5'd17,
    OP_RL     = 5'd18,
    OP_RR     = 5'd19,
    OP_SLA    = 5'd20,
    OP_SRA    = 5'd21,
    OP_SWAP   = 5'd22,
    OP_SRL    = 5'd23,
    OP_BIT    = 5'd24,
    OP_RES    = 5'd25,
    OP_SET    = 5'd26,
    OP_INC8   = 5'd27,
    OP_DEC8   = 5'd28,
    OP_ADD16  = 5'd29,
    OP_ADD_SP = 5'd30
  } op_t;

  // One operation as held in the input register.
  typedef struct packed {
    logic [OP_W-1:0]    req_type;
    logic [BYTE_W-1:0]  acc_in;
    logic [BYTE_W-1:0]  operand;
    logic [WORD_W-1:0]  wide_in;
    logic [WORD_W-1:0]  wide_operand;
    logic [BIDX_W-1:0]  bit_index;
    logic [FLAGS_W-1:0] flags_in;
  } req_t;

  // Result of one operation.
  typedef struct packed {
    logic [WORD_W-1:0]  result;
    logic [FLAGS_W-1:0] flags_out;
  } res_t;

endpackage

`default_nettype wire

### design/sm83_alu_exec.sv
// Combinational execution datapath: computes result and flags for one operation.
`default_nettype none

module sm83_alu_exec (
  input  sm83_alu_pkg::req_t req,
  output sm83_alu_pkg::res_t res
);
  import sm83_alu_pkg::*;

  function automatic logic zero8(input logic [BYTE_W-1:0] v);
    return (v == '0);
  endfunction

  logic [BYTE_W-1:0]  a;
  logic [BYTE_W-1:0]  v;
  logic [WORD_W-1:0]  w;
  logic [WORD_W-1:0]  wo;
  logic [FLAGS_W-1:0] f;
  logic               cin;
  logic               use_c;
  logic               flag_n_in;
  logic [BYTE_W:0]    sum9;
  logic [4:0]         sum_lo;
  logic [BYTE_W:0]    diff9;
  logic [4:0]         diff_lo;
  logic [BYTE_W-1:0]  rot_src;
  logic               daa_lo;
  logic               daa_hi;
  logic [BYTE_W-1:0]  daa_corr;
  logic [BYTE_W-1:0]  daa_val;
  logic [BYTE_W-1:0]  bit_mask;
  logic [BYTE_W-1:0]  inc_val;
  logic [BYTE_W-1:0]  dec_val;
  logic [WORD_W:0]    sum17;
  logic [12:0]        sum13;
  logic [WORD_W-1:0]  sp_sum;
  logic [4:0]         sp_lo;
  logic [BYTE_W:0]    sp_byte;
  logic [BYTE_W-1:0]  r8;
  logic [FLAGS_W-1:0] nf;
  logic [WORD_W-1:0]  r16;

  assign a         = req.acc_in;
  assign v         = req.operand;
  assign w         = req.wide_in;
  assign wo        = req.wide_operand;
  assign f         = req.flags_in;
  assign cin       = f[FLAG_C];
  assign flag_n_in = f[FLAG_N];

  // Carry in enters the sums and differences only in the with-carry forms.
  assign use_c   = ((op_t'(req.req_type) == OP_ADC) || (op_t'(req.req_type) == OP_SBC)) & cin;
  assign sum9    = {1'b0, a} + {1'b0, v} + {{BYTE_W{1'b0}}, use_c};
  assign sum_lo  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, use_c};
  assign diff9   = {1'b0, a} - {1'b0, v} - {{BYTE_W{1'b0}}, use_c};
  assign diff_lo = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, use_c};

  // Accumulator rotates work on A, the prefixed rotates on the operand.
  assign rot_src = req.req_type[4] ? v : a;

  assign daa_lo   = f[FLAG_H] | (~flag_n_in & (a[3:0] > 4'd9));
  assign daa_hi   = cin | (~flag_n_in & (a > 8'h99));
  assign daa_corr = {1'b0, daa_hi, daa_hi, 2'b00, daa_lo, daa_lo, 1'b0};
  assign daa_val  = flag_n_in ? (a - daa_corr) : (a + daa_corr);

  assign bit_mask = BYTE_W'(1) << req.bit_index;
  assign inc_val  = v + 8'd1;
  assign dec_val  = v - 8'd1;

  assign sum17   = {1'b0, w} + {1'b0, wo};
  assign sum13   = {1'b0, w[11:0]} + {1'b0, wo[11:0]};
  assign sp_sum  = w + {{BYTE_W{v[BYTE_W-1]}}, v};
  assign sp_lo   = {1'b0, w[3:0]} + {1'b0, v[3:0]};
  assign sp_byte = {1'b0, w[7:0]} + {1'b0, v};

  always_comb begin
    r8  = '0;
    r16 = '0;
    nf  = f;
    unique case (op_t'(req.req_type))
      OP_ADD, OP_ADC: begin
        r8 = sum9[BYTE_W-1:0];
        nf = {zero8(r8), 1'b0, sum_lo[4], sum9[BYTE_W]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r8 = (op_t'(req.req_type) == OP_CP) ? a : diff9[BYTE_W-1:0];
        nf = {zero8(diff9[BYTE_W-1:0]), 1'b1, diff_lo[4], diff9[BYTE_W]};
      end
      OP_AND: begin
        r8 = a & v;
        nf = {zero8(r8), 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        r8 = a ^ v;
        nf = {zero8(r8), 3'b000};
      end
      OP_OR: begin
        r8 = a | v;
        nf = {zero8(r8), 3'b000};
      end
      OP_RLCA, OP_RLC: begin
        r8 = {rot_src[6:0], rot_src[7]};
        nf = {req.req_type[4] & zero8(r8), 2'b00, rot_src[7]};
      end
      OP_RRCA, OP_RRC: begin
        r8 = {rot_src[0], rot_src[7:1]};
        nf = {req.req_type[4] & zero8(r8), 2'b00, rot_src[0]};
      end
      OP_RLA, OP_RL: begin
        r8 = {rot_src[6:0], cin};
        nf = {req.req_type[4] & zero8(r8), 2'b00, rot_src[7]};
      end
      OP_RRA, OP_RR: begin
        r8 = {cin, rot_src[7:1]};
        nf = {req.req_type[4] & zero8(r8), 2'b00, rot_src[0]};
      end
      OP_DAA: begin
        r8 = daa_val;
        nf = {zero8(r8), flag_n_in, 1'b0, daa_hi};
      end
      OP_CPL: begin
        r8 = ~a;
        nf = {f[FLAG_Z], 1'b1, 1'b1, cin};
      end
      OP_SCF: begin
        r8 = a;
        nf = {f[FLAG_Z], 2'b00, 1'b1};
      end
      OP_CCF: begin
        r8 = a;
        nf = {f[FLAG_Z], 2'b00, ~cin};
      end
      OP_SLA: begin
        r8 = {v[6:0], 1'b0};
        nf = {zero8(r8), 2'b00, v[7]};
      end
      OP_SRA: begin
        r8 = {v[7], v[7:1]};
        nf = {zero8(r8), 2'b00, v[0]};
      end
      OP_SWAP: begin
        r8 = {v[3:0], v[7:4]};
        nf = {zero8(r8), 3'b000};
      end
      OP_SRL: begin
        r8 = {1'b0, v[7:1]};
        nf = {zero8(r8), 2'b00, v[0]};
      end
      OP_BIT: begin
        r8 = v;
        nf = {~v[req.bit_index], 1'b0, 1'b1, cin};
      end
      OP_RES: begin
        r8 = v & ~bit_mask;
      end
      OP_SET: begin
        r8 = v | bit_mask;
      end
      OP_INC8: begin
        r8 = inc_val;
        nf = {zero8(r8), 1'b0, (v[3:0] == 4'hF), cin};
      end
      OP_DEC8: begin
        r8 = dec_val;
        nf = {zero8(r8), 1'b1, (v[3:0] == 4'h0), cin};
      end
      OP_ADD16: begin
        r16 = sum17[WORD_W-1:0];
        nf  = {f[FLAG_Z], 1'b0, sum13[12], sum17[WORD_W]};
      end
      OP_ADD_SP: begin
        r16 = sp_sum;
        nf  = {2'b00, sp_lo[4], sp_byte[BYTE_W]};
      end
      default: begin
        r8 = '0;
        nf = f;
      end
    endcase
  end

  // Only the two wide operations produce a full word; the others zero-extend.
  always_comb begin
    res.flags_out = nf;
    if ((op_t'(req.req_type) == OP_ADD16) || (op_t'(req.req_type) == OP_ADD_SP)) begin
      res.result = r16;
    end else begin
      res.result = {{(WORD_W-BYTE_W){1'b0}}, r8};
    end
  end

endmodule

`default_nettype wire

### design/sm83_alu_flags_unit.sv
// Top level of the SM83 ALU and flag unit: input register, datapath, result register.
`default_nettype none

// Usage
// An operation transaction is accepted at a rising clock edge where start is high
// and busy is low. The unit never stalls, so busy is held low and a new
// transaction may be issued in every cycle.
// The accepted fields are captured in an input register. The execution
// datapath then computes the result and new flags combinationally, and the
// outcome is captured in a result register.
// An accepted transaction passes through the input register and then the
// result register; out_valid is the valid bit of the result register, with
// out_result and out_flags_out beside the strobe.
// Throughput: one transaction per cycle; results come out in issue order.
// The receiver cannot hold results off. Each result is shown for a single
// cycle only and is taken at the edge that ends that cycle.
// Reset: rst_n is synchronous and active low. It clears the valid bits of
// both register stages, so no strobe follows reset until a new transaction
// is issued. The data registers are not reset.

module sm83_alu_flags_unit (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        start,
  output logic                                       busy,
  input  wire  [sm83_alu_pkg::OP_W-1:0]              in_req_type,
  input  wire  [sm83_alu_pkg::BYTE_W-1:0]            in_acc_in,
  input  wire  [sm83_alu_pkg::BYTE_W-1:0]            in_operand,
  input  wire  [sm83_alu_pkg::WORD_W-1:0]            in_wide_in,
  input  wire  [sm83_alu_pkg::WORD_W-1:0]            in_wide_operand,
  input  wire  [sm83_alu_pkg::BIDX_W-1:0]            in_bit_index,
  input  wire  [sm83_alu_pkg::FLAGS_W-1:0]           in_flags_in,
  output logic                                       out_valid,
  output logic [sm83_alu_pkg::WORD_W-1:0]            out_result,
  output logic [sm83_alu_pkg::FLAGS_W-1:0]           out_flags_out
);
  import sm83_alu_pkg::*;

  logic in_fire;
  logic req_valid_r;
  logic req_valid_nxt;
  req_t req_r;
  req_t req_nxt;
  res_t exec_res;
  logic res_valid_r;
  res_t res_r;

  // The pipeline always advances, so the unit is never busy.
  assign busy    = 1'b0;
  assign in_fire = start & ~busy;

  assign req_valid_nxt = in_fire;
  assign req_nxt = '{
    req_type:     in_req_type,
    acc_in:       in_acc_in,
    operand:      in_operand,
    wide_in:      in_wide_in,
    wide_operand: in_wide_operand,
    bit_index:    in_bit_index,
    flags_in:     in_flags_in
  };

  // Control state of both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      res_valid_r <= req_valid_r;
    end
  end

  // Payload registers load only when a transaction moves into them.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= req_nxt;
    end
    if (req_valid_r) begin
      res_r <= exec_res;
    end
  end

  sm83_alu_exec u_exec (
    .req (req_r),
    .res (exec_res)
  );

  assign out_valid     = res_valid_r;
  assign out_result    = res_r.result;
  assign out_flags_out = res_r.flags_out;

endmodule

`default_nettype wire

### design/sm83_alu_checker.sv
// Port-level checker for the SM83 ALU and flag unit, with its bind statement.
`default_nettype none

module sm83_alu_checker (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 start,
  input wire                                 busy,
  input wire [sm83_alu_pkg::OP_W-1:0]        in_req_type,
  input wire                                 out_valid,
  input wire [sm83_alu_pkg::FLAGS_W-1:0]     out_flags_out
);
  import sm83_alu_pkg::*;

  // Every accepted transaction produces a strobe after the input and result registers.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted transaction produced no result");

  // No strobe appears without a transaction accepted ahead of it through both registers.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> ##1 !out_valid)
    else $error("result strobe without an accepted transaction");

  // Reset empties the pipeline.
  a_reset_flushes: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // Setting the carry flag clears N and H and sets C, whatever came in.
  a_scf_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == OP_SCF)) |=> ##1
      (out_flags_out[FLAG_C] && !out_flags_out[FLAG_N] && !out_flags_out[FLAG_H]))
    else $error("carry set operation gave wrong flags");

endmodule

bind sm83_alu_flags_unit sm83_alu_checker u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_req_type   (in_req_type),
  .out_valid     (out_valid),
  .out_flags_out (out_flags_out)
);

`default_nettype wire

### bench/sm83_alu_flags_checker.sv
`timescale 1ns / 1ps
// Checker for the SM83 ALU unit: predicts each operation's outcome and compares the results.
module sm83_alu_flags_checker (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  input  wire                                 busy,
  input  wire [sm83_alu_pkg::OP_W-1:0]        in_req_type,
  input  wire [sm83_alu_pkg::BYTE_W-1:0]      in_acc_in,
  input  wire [sm83_alu_pkg::BYTE_W-1:0]      in_operand,
  input  wire [sm83_alu_pkg::WORD_W-1:0]      in_wide_in,
  input  wire [sm83_alu_pkg::WORD_W-1:0]      in_wide_operand,
  input  wire [sm83_alu_pkg::BIDX_W-1:0]      in_bit_index,
  input  wire [sm83_alu_pkg::FLAGS_W-1:0]     in_flags_in,
  input  wire                                 out_valid,
  input  wire [sm83_alu_pkg::WORD_W-1:0]      out_result,
  input  wire [sm83_alu_pkg::FLAGS_W-1:0]     out_flags_out,
  output int                                  mismatch_count,
  output int                                  pending_results
);
  import sm83_alu_pkg::*;

  localparam logic [BYTE_W-1:0] DAA_HIGH_LIMIT = 8'h99;
  localparam logic [BYTE_W-1:0] DAA_HIGH_ADJ   = 8'h60;
  localparam logic [BYTE_W-1:0] DAA_LOW_ADJ    = 8'h06;

  typedef struct packed {
    req_t rq;
    res_t rs;
  } outcome_t;

  outcome_t outcome_queue[$];

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  function automatic logic [FLAGS_W-1:0] pack_flags(input logic z, input logic n,
                                                    input logic h, input logic c);
    logic [FLAGS_W-1:0] f;
    f         = '0;
    f[FLAG_Z] = z;
    f[FLAG_N] = n;
    f[FLAG_H] = h;
    f[FLAG_C] = c;
    return f;
  endfunction

  function automatic res_t compute_alu_outcome(input req_t rq);
    logic [BYTE_W-1:0]  a, v, t, r8, adj;
    logic [WORD_W-1:0]  r16;
    logic [FLAGS_W-1:0] f, nf;
    logic               c, cy, wide, high, low;
    logic [8:0]         sum9;
    logic [4:0]         nib;
    logic [16:0]        sum17;
    logic [12:0]        sum13;
    res_t               rs;
    a    = rq.acc_in;
    v    = rq.operand;
    f    = rq.flags_in;
    c    = f[FLAG_C];
    nf   = f;
    r8   = '0;
    r16  = '0;
    wide = 1'b0;
    case (rq.req_type)
      OP_ADD, OP_ADC: begin
        cy   = (rq.req_type == OP_ADC) ? c : 1'b0;
        sum9 = {1'b0, a} + {1'b0, v} + 9'(cy);
        nib  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + 5'(cy);
        r8   = sum9[7:0];
        nf   = pack_flags(r8 == '0, 1'b0, nib[4], sum9[8]);
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // A borrow out of the 9-bit or 5-bit difference shows up in its top bit.
        cy   = (rq.req_type == OP_SBC) ? c : 1'b0;
        sum9 = {1'b0, a} - {1'b0, v} - 9'(cy);
        nib  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - 5'(cy);
        nf   = pack_flags(sum9[7:0] == '0, 1'b1, nib[4], sum9[8]);
        r8   = (rq.req_type == OP_CP) ? a : sum9[7:0];
      end
      OP_AND: begin
        r8 = a & v;
        nf = pack_flags(r8 == '0, 1'b0, 1'b1, 1'b0);
      end
      OP_XOR: begin
        r8 = a ^ v;
        nf = pack_flags(r8 == '0, 1'b0, 1'b0, 1'b0);
      end
      OP_OR: begin
        r8 = a | v;
        nf = pack_flags(r8 == '0, 1'b0, 1'b0, 1'b0);
      end
      OP_RLCA, OP_RLC: begin
        t  = (rq.req_type == OP_RLCA) ? a : v;
        r8 = {t[6:0], t[7]};
        nf = pack_flags((rq.req_type == OP_RLC) && (r8 == '0), 1'b0, 1'b0, t[7]);
      end
      OP_RRCA, OP_RRC: begin
        t  = (rq.req_type == OP_RRCA) ? a : v;
        r8 = {t[0], t[7:1]};
        nf = pack_flags((rq.req_type == OP_RRC) && (r8 == '0), 1'b0, 1'b0, t[0]);
      end
      OP_RLA, OP_RL: begin
        t  = (rq.req_type == OP_RLA) ? a : v;
        r8 = {t[6:0], c};
        nf = pack_flags((rq.req_type == OP_RL) && (r8 == '0), 1'b0, 1'b0, t[7]);
      end
      OP_RRA, OP_RR: begin
        t  = (rq.req_type == OP_RRA) ? a : v;
        r8 = {c, t[7:1]};
        nf = pack_flags((rq.req_type == OP_RR) && (r8 == '0), 1'b0, 1'b0, t[0]);
      end
      OP_DAA: begin
        low  = f[FLAG_H] || (!f[FLAG_N] && (a[3:0] > 4'd9));
        high = f[FLAG_C] || (!f[FLAG_N] && (a > DAA_HIGH_LIMIT));
        adj  = (high ? DAA_HIGH_ADJ : '0) | (low ? DAA_LOW_ADJ : '0);
        r8   = f[FLAG_N] ? (a - adj) : (a + adj);
        nf   = pack_flags(r8 == '0, f[FLAG_N], 1'b0, f[FLAG_C] | high);
      end
      OP_CPL: begin
        r8 = ~a;
        nf = pack_flags(f[FLAG_Z], 1'b1, 1'b1, c);
      end
      OP_SCF: begin
        r8 = a;
        nf = pack_flags(f[FLAG_Z], 1'b0, 1'b0, 1'b1);
      end
      OP_CCF: begin
        r8 = a;
        nf = pack_flags(f[FLAG_Z], 1'b0, 1'b0, ~c);
      end
      OP_SLA: begin
        r8 = {v[6:0], 1'b0};
        nf = pack_flags(r8 == '0, 1'b0, 1'b0, v[7]);
      end
      OP_SRA: begin
        r8 = {v[7], v[7:1]};
        nf = pack_flags(r8 == '0, 1'b0, 1'b0, v[0]);
      end
      OP_SWAP: begin
        r8 = {v[3:0], v[7:4]};
        nf = pack_flags(r8 == '0, 1'b0, 1'b0, 1'b0);
      end
      OP_SRL: begin
        r8 = {1'b0, v[7:1]};
        nf = pack_flags(r8 == '0, 1'b0, 1'b0, v[0]);
      end
      OP_BIT: begin
        r8 = v;
        nf = pack_flags(!v[rq.bit_index], 1'b0, 1'b1, c);
      end
      OP_RES: r8 = v & ~(8'h01 << rq.bit_index);
      OP_SET: r8 = v | (8'h01 << rq.bit_index);
      OP_INC8: begin
        r8 = v + 8'd1;
        nf = pack_flags(r8 == '0, 1'b0, v[3:0] == 4'hF, c);
      end
      OP_DEC8: begin
        r8 = v - 8'd1;
        nf = pack_flags(r8 == '0, 1'b1, v[3:0] == 4'h0, c);
      end
      OP_ADD16: begin
        wide  = 1'b1;
        sum17 = {1'b0, rq.wide_in} + {1'b0, rq.wide_operand};
        sum13 = {1'b0, rq.wide_in[11:0]} + {1'b0, rq.wide_operand[11:0]};
        r16   = sum17[15:0];
        nf    = pack_flags(f[FLAG_Z], 1'b0, sum13[12], sum17[16]);
      end
      OP_ADD_SP: begin
        // Sum is signed, but H and C come from the unsigned low-byte add.
        wide = 1'b1;
        r16  = rq.wide_in + {{8{v[7]}}, v};
        nib  = {1'b0, rq.wide_in[3:0]} + {1'b0, v[3:0]};
        sum9 = {1'b0, rq.wide_in[7:0]} + {1'b0, v};
        nf   = pack_flags(1'b0, 1'b0, nib[4], sum9[8]);
      end
      default: begin
        r8 = '0;
        nf = f;
      end
    endcase
    rs.result    = wide ? r16 : {8'h00, r8};
    rs.flags_out = nf;
    return rs;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    outcome_t want;
    req_t     rq;
    if (rst_n) begin
      if (out_valid) begin
        if (outcome_queue.size() == 0) begin
          report_mismatch($sformatf("result %h flags %h with no operation outstanding",
                                    out_result, out_flags_out));
        end else begin
          want = outcome_queue.pop_front();
          if (out_result !== want.rs.result) begin
            report_mismatch($sformatf("op %0d a=%h v=%h w=%h wo=%h b=%0d f=%h: result %h, want %h",
                                      want.rq.req_type, want.rq.acc_in, want.rq.operand,
                                      want.rq.wide_in, want.rq.wide_operand, want.rq.bit_index,
                                      want.rq.flags_in, out_result, want.rs.result));
          end
          if (out_flags_out !== want.rs.flags_out) begin
            report_mismatch($sformatf("op %0d a=%h v=%h w=%h wo=%h b=%0d f=%h: flags %h, want %h",
                                      want.rq.req_type, want.rq.acc_in, want.rq.operand,
                                      want.rq.wide_in, want.rq.wide_operand, want.rq.bit_index,
                                      want.rq.flags_in, out_flags_out, want.rs.flags_out));
          end
        end
      end
      if (start && !busy) begin
        rq.req_type     = in_req_type;
        rq.acc_in       = in_acc_in;
        rq.operand      = in_operand;
        rq.wide_in      = in_wide_in;
        rq.wide_operand = in_wide_operand;
        rq.bit_index    = in_bit_index;
        rq.flags_in     = in_flags_in;
        want.rq         = rq;
        want.rs         = compute_alu_outcome(rq);
        outcome_queue.push_back(want);
      end
    end
    pending_results = outcome_queue.size();
  end

endmodule

### bench/sm83_alu_flags_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the SM83 ALU unit: clock, reset, operation stimulus, watchdog and verdict.
module sm83_alu_flags_unit_tb;
  import sm83_alu_pkg::*;

  // The last 5-bit code, with no operation behind it; the unit must return zero
  // and pass the flags through.
  localparam logic [OP_W-1:0] OP_UNUSED = 5'd31;

  localparam int RANDOM_OPS   = 450;
  // The longest idle gap the sender draws plus the pipeline is far shorter, so a
  // quiet stretch of this length can only mean the unit or the bench is stuck.
  localparam int STALL_LIMIT  = 200;
  // Extra cycles after the last expected result, to catch stray strobes.
  localparam int DRAIN_CYCLES = 6;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic [OP_W-1:0]     in_req_type;
  logic [BYTE_W-1:0]   in_acc_in;
  logic [BYTE_W-1:0]   in_operand;
  logic [WORD_W-1:0]   in_wide_in;
  logic [WORD_W-1:0]   in_wide_operand;
  logic [BIDX_W-1:0]   in_bit_index;
  logic [FLAGS_W-1:0]  in_flags_in;
  wire                 busy;
  wire                 out_valid;
  wire [WORD_W-1:0]    out_result;
  wire [FLAGS_W-1:0]   out_flags_out;

  int mismatch_count;
  int pending_results;
  int idle_cycles = 0;
  // While this is nonzero the sender issues back to back with no gaps.
  int burst_left  = 0;

  sm83_alu_flags_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_acc_in       (in_acc_in),
    .in_operand      (in_operand),
    .in_wide_in      (in_wide_in),
    .in_wide_operand (in_wide_operand),
    .in_bit_index    (in_bit_index),
    .in_flags_in     (in_flags_in),
    .out_valid       (out_valid),
    .out_result      (out_result),
    .out_flags_out   (out_flags_out)
  );

  // The checker watches both channels on its own; this module drives the stimulus.
  sm83_alu_flags_checker u_flags_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_acc_in       (in_acc_in),
    .in_operand      (in_operand),
    .in_wide_in      (in_wide_in),
    .in_wide_operand (in_wide_operand),
    .in_bit_index    (in_bit_index),
    .in_flags_in     (in_flags_in),
    .out_valid       (out_valid),
    .out_result      (out_result),
    .out_flags_out   (out_flags_out),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic req_t make_req(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] a,
                                    input logic [BYTE_W-1:0] v, input logic [WORD_W-1:0] w,
                                    input logic [WORD_W-1:0] wo,
                                    input logic [BIDX_W-1:0] bi,
                                    input logic [FLAGS_W-1:0] f);
    req_t rq;
    rq.req_type     = op;
    rq.acc_in       = a;
    rq.operand      = v;
    rq.wide_in      = w;
    rq.wide_operand = wo;
    rq.bit_index    = bi;
    rq.flags_in     = f;
    return rq;
  endfunction

  // Bytes lean toward the all-zero and all-one corners and 0x80, where the flags flip.
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Words lean toward zero and the values where the 12-bit, 16-bit and low-byte carries appear.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0FFF;
      3:       return 16'h00FF;
      default: return WORD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Issues one operation transaction. The sender first idles for a random
  // number of cycles (none during a burst), then holds start high with the
  // fields until an edge accepts it. Busy is sampled on the falling edge so
  // that the decision never depends on event order at the rising edge. When
  // no gap is drawn, start simply stays high, so it is never lowered and
  // raised within one time step.
  task automatic issue_op(input req_t rq);
    int gap;
    bit took;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 15) == 0) begin
        burst_left = $urandom_range(8, 40);
      end
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_req_type     <= rq.req_type;
    in_acc_in       <= rq.acc_in;
    in_operand      <= rq.operand;
    in_wide_in      <= rq.wide_in;
    in_wide_operand <= rq.wide_operand;
    in_bit_index    <= rq.bit_index;
    in_flags_in     <= rq.flags_in;
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
  endtask

  // A cycle counts as progress when an operation is accepted or a result is
  // shown. Too many quiet cycles in a row end the run as a failure.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_req_type     <= '0;
    in_acc_in       <= '0;
    in_operand      <= '0;
    in_wide_in      <= '0;
    in_wide_operand <= '0;
    in_bit_index    <= '0;
    in_flags_in     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: carries and borrows out of both nibbles, zero results,
    // carry-in use, both decimal-adjust directions and its 0x99 boundary, the
    // carry-flag operations, bit test at the top bit, the 12-bit and 16-bit
    // carries of the HL add, a negative stack displacement and the unused code.
    issue_op(make_req(OP_ADD,    8'hFF, 8'h01, 16'h0000, 16'h0000, 3'd0, 4'b0000));
    issue_op(make_req(OP_ADC,    8'h0F, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'b0001));
    issue_op(make_req(OP_ADC,    8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7, 4'b1111));
    issue_op(make_req(OP_SUB,    8'h00, 8'h01, 16'h0000, 16'h0000, 3'd0, 4'b0000));
    issue_op(make_req(OP_SBC,    8'h10, 8'h0F, 16'h0000, 16'h0000, 3'd0, 4'b0001));
    issue_op(make_req(OP_CP,     8'h3C, 8'h3C, 16'h0000, 16'h0000, 3'd0, 4'b0000));
    issue_op(make_req(OP_AND,    8'hF0, 8'h0F, 16'h0000, 16'h0000, 3'd0, 4'b1111));
    issue_op(make_req(OP_XOR,    8'hFF, 8'hFF, 16'h0000, 16'h0000, 3'd0, 4'b0000));
    issue_op(make_req(OP_OR,     8'h00, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'b0111));
    issue_op(make_req(OP_RLA,    8'h80, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'b0001));
    issue_op(make_req(OP_RRA,    8'h01, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'b1000));
    issue_op(make_req(OP_DAA,    8'h9A, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'b0000));
    issue_op(make_req(OP_DAA,    8'h99, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'b0000));
    issue_op(make_req(OP_DAA,    8'h00, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'b0111));
    issue_op(make_req(OP_CPL,    8'h55, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'b1001));
    issue_op(make_req(OP_SCF,    8'hAA, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'b1110));
    issue_op(make_req(OP_CCF,    8'h01, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'b1111));
    issue_op(make_req(OP_BIT,    8'h00, 8'h7F, 16'h0000, 16'h0000, 3'd7, 4'b0000));
    issue_op(make_req(OP_BIT,    8'h00, 8'h80, 16'h0000, 16'h0000, 3'd7, 4'b1111));
    issue_op(make_req(OP_RES,    8'h00, 8'hFF, 16'h0000, 16'h0000, 3'd0, 4'b1010));
    issue_op(make_req(OP_SET,    8'h00, 8'h00, 16'h0000, 16'h0000, 3'd7, 4'b0101));
    issue_op(make_req(OP_INC8,   8'h00, 8'hFF, 16'h0000, 16'h0000, 3'd0, 4'b0001));
    issue_op(make_req(OP_DEC8,   8'h00, 8'h01, 16'h0000, 16'h0000, 3'd0, 4'b0000));
    issue_op(make_req(OP_DEC8,   8'h00, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'b1001));
    issue_op(make_req(OP_ADD16,  8'h00, 8'h00, 16'h0FFF, 16'h0001, 3'd0, 4'b0000));
    issue_op(make_req(OP_ADD16,  8'h00, 8'h00, 16'hFFFF, 16'h0001, 3'd0, 4'b1000));
    issue_op(make_req(OP_ADD_SP, 8'h00, 8'h01, 16'h00FF, 16'h0000, 3'd0, 4'b1111));
    issue_op(make_req(OP_ADD_SP, 8'h00, 8'h80, 16'h0000, 16'h0000, 3'd0, 4'b0000));
    issue_op(make_req(OP_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7, 4'b1111));

    // Random part: every code, including the unused one, with fields that
    // lean toward their corners and flags fully random.
    for (int i = 0; i < RANDOM_OPS; i++) begin
      issue_op(make_req(OP_W'($urandom_range(0, 31)), pick_byte(), pick_byte(), pick_word(),
                        pick_word(), BIDX_W'($urandom_range(0, 7)),
                        FLAGS_W'($urandom_range(0, 15))));
    end
    start <= 1'b0;

    // Wait for every outstanding transaction, then a few more cycles for
    // anything unexpected. Both are read on the falling edge, away from the
    // checker's updates.
    do @(negedge clk); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
design/sm83_alu_pkg.sv
design/sm83_alu_exec.sv
design/sm83_alu_flags_unit.sv
design/sm83_alu_checker.sv
bench/sm83_alu_flags_checker.sv
bench/sm83_alu_flags_unit_tb.sv
